@@ hdl/error_diffusion_halftoner_top_macros.svh @@
// assertion helpers used by the checker of this block
// clock and reset names follow the block's port convention
`ifndef ERROR_DIFFUSION_HALFTONER_TOP_MACROS_SVH
`define ERROR_DIFFUSION_HALFTONER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define EDH_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edh assertion failed");

// antecedent implies consequent in the next cycle
`define EDH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edh assertion failed");

`endif

@@ hdl/edh_pkg.sv @@
`default_nettype none

package edh_pkg;

  // sizing
  localparam int unsigned MAX_LINE_WIDTH = 1024;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned LINE_WIDTH_W   = 11;
  localparam int unsigned FRAME_HEIGHT_W = 12;
  localparam int unsigned ERR_W          = 11;
  localparam int unsigned CARRY_W        = 10;
  localparam int unsigned DIAG_W         = 7;
  localparam int unsigned CORR_W         = 13;
  localparam int unsigned PROD_W         = 15;

  // configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // register reset values
  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd750;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd500;
  localparam logic [PIX_W-1:0]          THRESHOLD_RST    = 8'd128;

  // pixel levels and error saturation bounds
  localparam logic [PIX_W-1:0]        PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0]        PIX_BLACK = 8'd0;
  localparam logic signed [ERR_W-1:0] ERR_MIN   = 11'sh400;
  localparam logic signed [ERR_W-1:0] ERR_MAX   = 11'sh3FF;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LINE_WIDTH_W-1:0]   line_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
    logic [PIX_W-1:0]          threshold;
  } cfg_t;

  // signed divide by 16 rounding toward zero
  function automatic logic signed [ERR_W-1:0] div16(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] biased;
    biased = x + (x[PROD_W-1] ? 15'sd15 : 15'sd0);
    return ERR_W'(biased >>> 4);
  endfunction

endpackage

`default_nettype wire

@@ hdl/edh_if.sv @@
`default_nettype none

// raw pixel channel
interface edh_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [edh_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// halftoned pixel channel
interface edh_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [edh_pkg::PIX_W-1:0] pixel_out;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/error_diffusion_halftoner_top.sv @@
// Floyd-Steinberg error diffusion halftoner, grayscale in, 0/255 out.
// pix_i takes one raw pixel per transfer in raster order; pix_o returns one
// halftoned pixel per input, with row_end on the last pixel of a row and
// frame_end on the last pixel of the frame. Geometry and threshold come in
// through the APB port (line_width at 0x0, frame_height at 0x4, threshold
// at 0x8). The user must write them only while idle; the block does not enforce it.
// Throughput is one pixel per clock while pix_o.ready stays high: the error
// line store is split into an even and an odd column bank, each with one
// write and one read port, so a pixel's two neighbor write-backs and the
// next pixel's read happen in the same cycle. The line store is read and
// the compute stage loaded on the input transfer; threshold and diffusion
// then load the output register, which drives pix_o.
// After reset the line store is zeroed, one even/odd pair per cycle, over
// all (MAX_LINE_WIDTH+1)/2 bank addresses (512 by default); pix_i.ready stays
// low until it is done, configuration writes are taken meanwhile.
// When the receiver stalls, the result is held on pix_o and pix_i.ready
// drops once the compute stage holds a pixel; an empty one still takes one.
`default_nettype none

module error_diffusion_halftoner_top #(
  parameter int unsigned MAX_LINE_WIDTH = edh_pkg::MAX_LINE_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  edh_pix_in_if.sink                  pix_i,
  edh_pix_out_if.source               pix_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [edh_pkg::APB_AW-1:0]  paddr,
  input  logic [edh_pkg::APB_DW-1:0]  pwdata,
  output logic [edh_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  edh_pkg::cfg_t cfg;

  // configuration registers, no wait states
  assign pready = 1'b1;

  edh_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // pixel pipeline around the line store
  edh_core #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix_i),
    .pix_o  (pix_o)
  );

endmodule

`default_nettype wire

@@ hdl/edh_ram.sv @@
`default_nettype none

module edh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/edh_regs.sv @@
`default_nettype none

module edh_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [edh_pkg::APB_AW-1:0]  paddr_i,
  input  logic [edh_pkg::APB_DW-1:0]  pwdata_i,
  output logic [edh_pkg::APB_DW-1:0]  prdata_o,
  output edh_pkg::cfg_t               cfg_o
);

  edh_pkg::cfg_t     cfg_q;
  edh_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx   = edh_pkg::reg_idx_e'(paddr_i[edh_pkg::APB_AW-1:2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width   <= edh_pkg::LINE_WIDTH_RST;
      cfg_q.frame_height <= edh_pkg::FRAME_HEIGHT_RST;
      cfg_q.threshold    <= edh_pkg::THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        edh_pkg::REG_LINE_WIDTH: begin
          cfg_q.line_width <= pwdata_i[edh_pkg::LINE_WIDTH_W-1:0];
        end
        edh_pkg::REG_FRAME_HEIGHT: begin
          cfg_q.frame_height <= pwdata_i[edh_pkg::FRAME_HEIGHT_W-1:0];
        end
        edh_pkg::REG_THRESHOLD: begin
          cfg_q.threshold <= pwdata_i[edh_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      edh_pkg::REG_LINE_WIDTH:   prdata_o = edh_pkg::APB_DW'(cfg_q.line_width);
      edh_pkg::REG_FRAME_HEIGHT: prdata_o = edh_pkg::APB_DW'(cfg_q.frame_height);
      edh_pkg::REG_THRESHOLD:    prdata_o = edh_pkg::APB_DW'(cfg_q.threshold);
      default:                   prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/edh_core.sv @@
`default_nettype none

module edh_core #(
  parameter int unsigned MAX_LINE_WIDTH = edh_pkg::MAX_LINE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  edh_pkg::cfg_t         cfg_i,
  edh_pix_in_if.sink            pix_i,
  edh_pix_out_if.source         pix_o
);

  localparam int unsigned CW         = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW         = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned LWW        = (WW > edh_pkg::LINE_WIDTH_W) ? WW
                                                                    : edh_pkg::LINE_WIDTH_W;
  localparam int unsigned BANK_DEPTH = (MAX_LINE_WIDTH + 1) / 2;
  localparam int unsigned BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned EW         = edh_pkg::ERR_W;
  localparam int unsigned HW         = edh_pkg::FRAME_HEIGHT_W;
  localparam int unsigned PW         = edh_pkg::PIX_W;

  // clearing pass
  logic           clr_busy_q;
  logic [BAW-1:0] clr_cnt_q;

  // scan position
  logic [CW-1:0]  col_q;
  logic [HW-1:0]  row_q;

  // compute stage
  logic           s1_valid_q;
  logic [PW-1:0]  s1_pix_q;
  logic [CW-1:0]  s1_col_q;
  logic           s1_last_col_q;
  logic           s1_last_row_q;
  logic           fwd_hit_q;
  logic [EW-1:0]  fwd_data_q;

  // diffusion carries
  logic signed [edh_pkg::CARRY_W-1:0] rec_q;
  logic signed [EW-1:0]               blp_q;
  logic signed [edh_pkg::DIAG_W-1:0]  diag_q;

  // output register
  logic           out_valid_q;
  logic [PW-1:0]  pixel_out_q;
  logic           row_end_q;
  logic           frame_end_q;

  // handshake
  logic out_free, s1_adv, in_ready, accept;

  // position decode
  logic [LWW-1:0] lw_ext, w_eff, w_last, col_ext;
  logic [HW-1:0]  h_eff, h_last;
  logic [CW-1:0]  col;
  logic [HW-1:0]  row;
  logic           last_col, last_row;

  // line store ports
  logic [BAW-1:0] rd_addr, s1_half;
  logic           even_we, odd_we;
  logic [BAW-1:0] even_wa, odd_wa;
  logic [EW-1:0]  even_wd, odd_wd, even_rd, odd_rd;
  logic           fwd_hit;
  logic [EW-1:0]  fwd_data;

  // datapath
  logic signed [EW-1:0]                mem_val;
  logic signed [edh_pkg::CORR_W-1:0]   corr, thr_ext, diff;
  logic                                white;
  logic signed [EW-1:0]                err;
  logic signed [edh_pkg::PROD_W-1:0]   err_ext;
  logic signed [EW-1:0]                s7, s3, s5, s1;
  logic signed [EW-1:0]                below, left;
  logic [EW-1:0]                       below_wd, left_wd;

  assign out_free = !out_valid_q || pix_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign in_ready = !clr_busy_q && (!s1_valid_q || out_free);
  assign accept   = pix_i.valid && in_ready;

  // effective geometry and current position
  always_comb begin
    lw_ext = LWW'(cfg_i.line_width);
    priority if (lw_ext == '0) begin
      w_eff = LWW'(1);
    end else if (lw_ext > LWW'(MAX_LINE_WIDTH)) begin
      w_eff = LWW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    w_last   = w_eff - LWW'(1);
    col_ext  = LWW'(col_q);
    last_col = (col_ext >= w_last);
    col      = last_col ? w_last[CW-1:0] : col_q;

    h_eff    = (cfg_i.frame_height == '0) ? HW'(1) : cfg_i.frame_height;
    h_last   = h_eff - HW'(1);
    last_row = (row_q >= h_last);
    row      = last_row ? h_last : row_q;
  end

  // line store writes: zeros while clearing, else left neighbor and own column land in opposite banks
  always_comb begin
    s1_half = BAW'(s1_col_q >> 1);
    if (clr_busy_q) begin
      even_we = 1'b1;
      even_wa = clr_cnt_q;
      even_wd = '0;
      odd_we  = 1'b1;
      odd_wa  = clr_cnt_q;
      odd_wd  = '0;
    end else begin
      even_we = s1_adv;
      even_wa = s1_half;
      even_wd = s1_col_q[0] ? left_wd : below_wd;
      odd_we  = s1_adv && (s1_col_q[0] || (s1_col_q != '0));
      odd_wa  = s1_col_q[0] ? s1_half : (s1_half - BAW'(1));
      odd_wd  = s1_col_q[0] ? below_wd : left_wd;
    end
  end

  // read address and same-edge write forwarding
  always_comb begin
    rd_addr = BAW'(col >> 1);
    if (col[0]) begin
      fwd_hit  = accept && odd_we && (odd_wa == rd_addr);
      fwd_data = odd_wd;
    end else begin
      fwd_hit  = accept && even_we && (even_wa == rd_addr);
      fwd_data = even_wd;
    end
  end

  edh_ram #(
    .WIDTH (EW),
    .DEPTH (BANK_DEPTH)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (even_wa),
    .wdata_i (even_wd),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (even_rd)
  );

  edh_ram #(
    .WIDTH (EW),
    .DEPTH (BANK_DEPTH)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (odd_wa),
    .wdata_i (odd_wd),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (odd_rd)
  );

  // threshold, error and shares
  always_comb begin
    mem_val = fwd_hit_q ? fwd_data_q : (s1_col_q[0] ? odd_rd : even_rd);
    corr    = edh_pkg::CORR_W'(s1_pix_q) + edh_pkg::CORR_W'(rec_q)
            + edh_pkg::CORR_W'(mem_val);
    thr_ext = edh_pkg::CORR_W'(cfg_i.threshold);
    white   = (corr >= thr_ext);
    diff    = corr - (white ? 13'sd255 : 13'sd0);
    priority if (diff < edh_pkg::CORR_W'(edh_pkg::ERR_MIN)) begin
      err = edh_pkg::ERR_MIN;
    end else if (diff > edh_pkg::CORR_W'(edh_pkg::ERR_MAX)) begin
      err = edh_pkg::ERR_MAX;
    end else begin
      err = diff[EW-1:0];
    end
    err_ext  = edh_pkg::PROD_W'(err);
    s7       = edh_pkg::div16(err_ext * 15'sd7);
    s3       = edh_pkg::div16(err_ext * 15'sd3);
    s5       = edh_pkg::div16(err_ext * 15'sd5);
    s1       = edh_pkg::div16(err_ext);
    below    = s5 + EW'(diag_q);
    left     = blp_q + s3;
    below_wd = s1_last_row_q ? '0 : below;
    left_wd  = s1_last_row_q ? '0 : left;
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + BAW'(1);
      if (clr_cnt_q == BAW'(BANK_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // scan position advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : (row + HW'(1));
      end else begin
        col_q <= col + CW'(1);
        row_q <= row;
      end
    end
  end

  // compute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // compute stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q      <= pix_i.pixel_in;
      s1_col_q      <= col;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
      fwd_hit_q     <= fwd_hit;
      fwd_data_q    <= fwd_data;
    end
  end

  // error carries along the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q  <= '0;
      blp_q  <= '0;
      diag_q <= '0;
    end else if (s1_adv) begin
      if (s1_last_col_q) begin
        rec_q  <= '0;
        blp_q  <= '0;
        diag_q <= '0;
      end else begin
        rec_q  <= s7[edh_pkg::CARRY_W-1:0];
        blp_q  <= below;
        diag_q <= s1[edh_pkg::DIAG_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_out_q <= white ? edh_pkg::PIX_WHITE : edh_pkg::PIX_BLACK;
      row_end_q   <= s1_last_col_q;
      frame_end_q <= s1_last_col_q && s1_last_row_q;
    end
  end

  assign pix_i.ready     = in_ready;
  assign pix_o.valid     = out_valid_q;
  assign pix_o.pixel_out = pixel_out_q;
  assign pix_o.row_end   = row_end_q;
  assign pix_o.frame_end = frame_end_q;

endmodule

`default_nettype wire

@@ hdl/edh_checker.sv @@
`default_nettype none
`include "error_diffusion_halftoner_top_macros.svh"

module edh_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [edh_pkg::PIX_W-1:0] pixel_out_i,
  input logic                      row_end_i,
  input logic                      frame_end_i
);

  // a stalled result keeps its payload
  `EDH_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(pixel_out_i) && $stable(row_end_i) && $stable(frame_end_i))

  // output is strictly bilevel
  `EDH_ASSERT_IMPLIES(a_out_bilevel, out_valid_i, pixel_out_i == 8'd0 || pixel_out_i == 8'd255)

  // a frame ends on a row end
  `EDH_ASSERT_IMPLIES(a_frame_on_row, out_valid_i && frame_end_i, row_end_i)

  // a fresh result follows an input transfer through the compute stage and the output register
  `EDH_ASSERT_IMPLIES(a_out_from_in, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

endmodule

bind error_diffusion_halftoner_top edh_checker u_edh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .pixel_out_i (pix_o.pixel_out),
  .row_end_i   (pix_o.row_end),
  .frame_end_i (pix_o.frame_end)
);

`default_nettype wire

@@ tb/tb_error_diffusion_halftoner_top.sv @@
`timescale 1ns / 1ps

module tb_error_diffusion_halftoner_top;

  localparam int LINE_STORE_DEPTH = edh_pkg::MAX_LINE_WIDTH;
  localparam int PIPE_LATENCY     = 2;
  localparam int WHITE_LEVEL      = 255;

  // one halftoned pixel as seen on the output channel
  typedef struct packed {
    logic [edh_pkg::PIX_W-1:0] pixel_out;
    logic                      row_end;
    logic                      frame_end;
  } halftone_t;

  // content of the pixels within one random phase
  typedef enum int {
    TONE_NOISE,
    TONE_FLAT,
    TONE_BINARY,
    TONE_NEAR
  } tone_style_e;

  logic clk = 1'b0;
  logic rst_n;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [edh_pkg::APB_AW-1:0]   paddr;
  logic [edh_pkg::APB_DW-1:0]   pwdata;
  logic [edh_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  edh_pix_in_if  pix_in_bus ();
  edh_pix_out_if pix_out_bus ();

  error_diffusion_halftoner_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pix_i   (pix_in_bus),
    .pix_o   (pix_out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // predictor state: registers, error line store, carries and position
  logic [edh_pkg::LINE_WIDTH_W-1:0]   cfg_line_width;
  logic [edh_pkg::FRAME_HEIGHT_W-1:0] cfg_frame_height;
  logic [edh_pkg::PIX_W-1:0]          cfg_threshold;
  logic signed [edh_pkg::ERR_W-1:0]   err_line [LINE_STORE_DEPTH];
  logic signed [edh_pkg::CARRY_W-1:0] carry_right;
  logic signed [edh_pkg::ERR_W-1:0]   partial_below_left;
  logic signed [edh_pkg::DIAG_W-1:0]  diag_pending;
  logic [9:0]                         col_pos;
  logic [edh_pkg::FRAME_HEIGHT_W-1:0] row_pos;

  halftone_t halftone_q [$];
  int        fail_count = 0;

  bit src_idle_en   = 1'b0;
  bit sink_stall_en = 1'b0;
  int sink_hold_req = 0;

  // halftone one pixel, update the diffusion state and queue the expected result
  function automatic void predict_halftone(input logic [edh_pkg::PIX_W-1:0] pix);
    int w, h, col, row, px, thr, corr, outv, err, s7, s3, s5, s1, below;
    bit last_col, last_row;
    halftone_t res;
    w = cfg_line_width;
    h = cfg_frame_height;
    if (w == 0) w = 1;
    if (w > LINE_STORE_DEPTH) w = LINE_STORE_DEPTH;
    if (h == 0) h = 1;
    col = col_pos;
    if (col >= w) col = w - 1;
    row = row_pos;
    if (row >= h) row = h - 1;
    last_col = (col == w - 1);
    last_row = (row == h - 1);

    px   = pix;
    thr  = cfg_threshold;
    corr = px + carry_right + err_line[col];
    outv = (corr >= thr) ? WHITE_LEVEL : 0;
    err  = corr - outv;
    if (err < edh_pkg::ERR_MIN) err = edh_pkg::ERR_MIN;
    if (err > edh_pkg::ERR_MAX) err = edh_pkg::ERR_MAX;

    // shares truncate toward zero
    s7 = (err * 7) / 16;
    s3 = (err * 3) / 16;
    s5 = (err * 5) / 16;
    s1 = err / 16;
    below = s5 + diag_pending;

    // the last row leaves a clean line store for the next frame
    if (last_row) begin
      if (col > 0) err_line[col - 1] = '0;
      err_line[col] = '0;
    end else begin
      if (col > 0) err_line[col - 1] = edh_pkg::ERR_W'(partial_below_left + s3);
      err_line[col] = edh_pkg::ERR_W'(below);
    end

    if (last_col) begin
      carry_right        = '0;
      partial_below_left = '0;
      diag_pending       = '0;
      col_pos            = '0;
      row_pos            = last_row ? '0 : edh_pkg::FRAME_HEIGHT_W'(row + 1);
    end else begin
      carry_right        = edh_pkg::CARRY_W'(s7);
      partial_below_left = edh_pkg::ERR_W'(below);
      diag_pending       = edh_pkg::DIAG_W'(s1);
      col_pos            = 10'(col + 1);
      row_pos            = edh_pkg::FRAME_HEIGHT_W'(row);
    end

    res.pixel_out = (outv == WHITE_LEVEL) ? edh_pkg::PIX_WHITE : edh_pkg::PIX_BLACK;
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    halftone_q.push_back(res);
  endfunction

  // offer one raw pixel, with an occasional idle burst ahead of it
  task automatic send_pixel(input logic [edh_pkg::PIX_W-1:0] pix);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      pix_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.pixel_in <= pix;
    do @(posedge clk); while (!pix_in_bus.ready);
    predict_halftone(pix);
  endtask

  // stop offering pixels and wait for every outstanding result
  task automatic drain_results();
    pix_in_bus.valid <= 1'b0;
    while (halftone_q.size() != 0) @(posedge clk);
  endtask

  // APB write with setup and access cycle, only while the stream is idle
  task automatic write_reg(input edh_pkg::reg_idx_e idx,
                           input logic [edh_pkg::APB_DW-1:0] value);
    drain_results();
    repeat (PIPE_LATENCY) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      edh_pkg::REG_LINE_WIDTH:   cfg_line_width   = value[edh_pkg::LINE_WIDTH_W-1:0];
      edh_pkg::REG_FRAME_HEIGHT: cfg_frame_height = value[edh_pkg::FRAME_HEIGHT_W-1:0];
      edh_pkg::REG_THRESHOLD:    cfg_threshold    = value[edh_pkg::PIX_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [edh_pkg::PIX_W-1:0] pick_pixel(
      input tone_style_e style, input logic [edh_pkg::PIX_W-1:0] level);
    case (style)
      TONE_NOISE:  return edh_pkg::PIX_W'($urandom_range(0, 255));
      TONE_FLAT:   return level;
      TONE_BINARY: return $urandom_range(0, 1) ? edh_pkg::PIX_WHITE : edh_pkg::PIX_BLACK;
      default:     return level ^ edh_pkg::PIX_W'($urandom_range(0, 7));
    endcase
  endfunction

  // field extremes, zero geometry, threshold extremes, position past the end
  task automatic test_directed_cases();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    // reset geometry, a few pixels into the first row
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    send_pixel(8'd127);
    // row narrower than the current column: next pixel closes the row
    write_reg(edh_pkg::REG_LINE_WIDTH, 3);
    write_reg(edh_pkg::REG_FRAME_HEIGHT, 2);
    send_pixel(8'd200);
    send_pixel(8'd55);
    send_pixel(8'd170);
    send_pixel(8'd85);
    // zero width and height act as one
    write_reg(edh_pkg::REG_LINE_WIDTH, 0);
    write_reg(edh_pkg::REG_FRAME_HEIGHT, 0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    // threshold extremes on a 4x2 frame
    write_reg(edh_pkg::REG_LINE_WIDTH, 4);
    write_reg(edh_pkg::REG_FRAME_HEIGHT, 2);
    write_reg(edh_pkg::REG_THRESHOLD, 0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    write_reg(edh_pkg::REG_THRESHOLD, 255);
    send_pixel(8'd254);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd128);
    // tallest frame, then a height below the current row ends the frame
    write_reg(edh_pkg::REG_LINE_WIDTH, 2);
    write_reg(edh_pkg::REG_FRAME_HEIGHT, 4095);
    write_reg(edh_pkg::REG_THRESHOLD, 128);
    send_pixel(8'd90);
    send_pixel(8'd160);
    write_reg(edh_pkg::REG_FRAME_HEIGHT, 1);
    send_pixel(8'd30);
    send_pixel(8'd240);
  endtask

  // long receiver hold-off fills the pipe, then the sender pauses until drained
  task automatic test_output_backpressure();
    write_reg(edh_pkg::REG_LINE_WIDTH, 8);
    write_reg(edh_pkg::REG_FRAME_HEIGHT, 3);
    write_reg(edh_pkg::REG_THRESHOLD, 100);
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    sink_hold_req = 60;
    repeat (24) send_pixel(edh_pkg::PIX_W'($urandom_range(0, 255)));
    drain_results();
    repeat (24) send_pixel(edh_pkg::PIX_W'($urandom_range(0, 255)));
  endtask

  // random geometry and threshold per phase, mostly whole frames
  task automatic run_random_frames(input int item_goal);
    int sent, w, h, thr, cap;
    bit whole_frame;
    tone_style_e style;
    logic [edh_pkg::PIX_W-1:0] level;
    sent = 0;
    while (sent < item_goal) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(0, 2047);
        default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = $urandom_range(0, 4095);
        default: h = $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 7))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      write_reg(edh_pkg::REG_LINE_WIDTH, w);
      write_reg(edh_pkg::REG_FRAME_HEIGHT, h);
      write_reg(edh_pkg::REG_THRESHOLD, thr);

      // broken frames leave the position mid-frame for the next geometry
      whole_frame = ($urandom_range(0, 4) != 0);
      cap         = whole_frame ? 200 : $urandom_range(1, 30);
      style       = tone_style_e'($urandom_range(0, 3));
      level       = edh_pkg::PIX_W'($urandom_range(0, 255));
      for (int k = 0; k < cap; k++) begin
        send_pixel(pick_pixel(style, level));
        sent++;
        if (whole_frame && col_pos == 0 && row_pos == 0) break;
      end
    end
  endtask

  // receiver: long hold-off on request, else random stall bursts
  initial begin : sink_ready
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    pix_out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_bus.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pix_out_bus.ready <= 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 14);
        pix_out_bus.ready <= 1'b0;
      end else begin
        pix_out_bus.ready <= 1'b1;
      end
    end
  end

  // compare each output transfer with the oldest expected pixel
  always @(posedge clk) begin : check_halftone
    halftone_t exp_px;
    if (rst_n && pix_out_bus.valid && pix_out_bus.ready) begin
      if (halftone_q.size() == 0) begin
        $error("result with no expected pixel: pixel_out %0d", pix_out_bus.pixel_out);
        fail_count++;
      end else begin
        exp_px = halftone_q.pop_front();
        if (pix_out_bus.pixel_out !== exp_px.pixel_out) begin
          $error("pixel_out mismatch: expected %0d, actual %0d",
                 exp_px.pixel_out, pix_out_bus.pixel_out);
          fail_count++;
        end
        if (pix_out_bus.row_end !== exp_px.row_end) begin
          $error("row_end mismatch: expected %0d, actual %0d",
                 exp_px.row_end, pix_out_bus.row_end);
          fail_count++;
        end
        if (pix_out_bus.frame_end !== exp_px.frame_end) begin
          $error("frame_end mismatch: expected %0d, actual %0d",
                 exp_px.frame_end, pix_out_bus.frame_end);
          fail_count++;
        end
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pix_in_bus.valid    = 1'b0;
    pix_in_bus.pixel_in = '0;

    cfg_line_width     = edh_pkg::LINE_WIDTH_RST;
    cfg_frame_height   = edh_pkg::FRAME_HEIGHT_RST;
    cfg_threshold      = edh_pkg::THRESHOLD_RST;
    carry_right        = '0;
    partial_below_left = '0;
    diag_pending       = '0;
    col_pos            = '0;
    row_pos            = '0;
    foreach (err_line[i]) err_line[i] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_output_backpressure();
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    run_random_frames(730);
    // closing stretch at full rate
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    run_random_frames(150);

    drain_results();
    repeat (PIPE_LATENCY * 8) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
